// ===== rtl/core/fts_pkg.sv =====
`default_nettype none
package fts_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [7:0] primary_byte;
    logic [7:0] copy_byte;
    logic       last_byte;
  } fts_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] bad_cluster_number;
    logic [15:0] free_total;
    logic [15:0] bad_total;
    logic [15:0] reserved_total;
    logic [15:0] end_marker_total;
    logic [15:0] allocated_total;
    logic [23:0] mismatch_total;
    logic [15:0] entry_zero;
    logic [15:0] entry_one;
    logic        media_differs;
    logic        final_item;
  } fts_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } fts_cfg_wr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAT16_MODE    = 8'd0,
    CFG_CLUSTER_LIMIT = 8'd1,
    CFG_COMPARE       = 8'd2,
    CFG_MEDIA         = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        fat16_mode;
    logic [15:0] cluster_limit;
    logic        compare_copies;
    logic [7:0]  media_byte;
  } fts_cfg_t;

  // running totals of the current table
  typedef struct packed {
    logic [15:0] free_cnt;
    logic [15:0] bad_cnt;
    logic [15:0] rsv_cnt;
    logic [15:0] eoc_cnt;
    logic [15:0] alloc_cnt;
    logic [23:0] mismatch_cnt;
    logic [15:0] entry_zero;
    logic [15:0] entry_one;
  } fts_stats_t;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_RD,
    EMIT_LOAD,
    EMIT_SUM
  } emit_state_t;

  localparam logic ITEM_LIST    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  localparam logic [11:0] F12_RSV_LO = 12'hFF0;
  localparam logic [11:0] F12_RSV_HI = 12'hFF6;
  localparam logic [11:0] F12_BAD    = 12'hFF7;
  localparam logic [11:0] F12_EOC    = 12'hFF8;
  localparam logic [15:0] F16_BAD    = 16'hFFF7;
  localparam logic [15:0] F16_EOC    = 16'hFFF8;

  localparam logic [15:0] CNT_MAX      = 16'hFFFF;
  localparam logic [23:0] MISMATCH_MAX = 24'hFFFFFF;
  localparam logic [16:0] ENTRY_SAT    = 17'h10000;

  localparam logic [15:0] CLUSTER_LIMIT_RST = 16'd1;
  localparam logic [7:0]  MEDIA_RST         = 8'hF0;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fts_if.sv =====
`default_nettype none
interface fts_in_if import fts_pkg::*;;
  logic    valid;
  logic    ready;
  fts_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_out_if import fts_pkg::*;;
  logic     valid;
  logic     ready;
  fts_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_cfg_if import fts_pkg::*;;
  logic        valid;
  logic        ready;
  fts_cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fts_ram.sv =====
`default_nettype none
module fts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/core/fts_scan.sv =====
`default_nettype none
module fts_scan import fts_pkg::*; #(
  parameter int BAD_LIST_DEPTH = 32,
  localparam int FW = $clog2(BAD_LIST_DEPTH + 1),
  localparam int AW = (BAD_LIST_DEPTH > 1) ? $clog2(BAD_LIST_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fts_cfg_t        cfg,
  input  wire logic            take,
  input  wire fts_in_t         in_data,
  input  wire logic            clear,
  output logic                 last_pending,
  output fts_stats_t           stats,
  output logic [FW-1:0]        fill,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [15:0]          ram_wdata
);
  logic           in_vld_r;
  fts_in_t        in_r;
  logic [1:0]     pos_r, pos_nxt;
  logic [15:0]    pend_r, pend_nxt;
  logic [16:0]    idx_r, idx_nxt;
  fts_stats_t     st_r, st_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;

  logic           ent_vld;
  logic [15:0]    ent;
  logic           is_free, is_bad, is_rsv, is_eoc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      pos_r    <= 2'd0;
      pend_r   <= 16'd0;
      idx_r    <= 17'd0;
      st_r     <= '0;
      fill_r   <= '0;
    end else begin
      in_vld_r <= take;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
      idx_r    <= idx_nxt;
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_data;
    end
  end

  // entry assembly from the byte stream
  always_comb begin
    ent_vld  = 1'b0;
    ent      = 16'd0;
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    if (clear) begin
      pos_nxt  = 2'd0;
      pend_nxt = 16'd0;
    end else if (in_vld_r) begin
      if (cfg.fat16_mode) begin
        if (pos_r == 2'd1) begin
          ent_vld = 1'b1;
          ent     = {in_r.primary_byte, pend_r[7:0]};
          pos_nxt = 2'd0;
        end else begin
          pend_nxt = {8'd0, in_r.primary_byte};
          pos_nxt  = 2'd1;
        end
      end else begin
        case (pos_r)
          2'd0: begin
            pend_nxt = {8'd0, in_r.primary_byte};
            pos_nxt  = 2'd1;
          end
          2'd1: begin
            ent_vld  = 1'b1;
            ent      = {4'd0, in_r.primary_byte[3:0], pend_r[7:0]};
            pend_nxt = {in_r.primary_byte, pend_r[7:0]};
            pos_nxt  = 2'd2;
          end
          default: begin
            ent_vld = 1'b1;
            ent     = {4'd0, in_r.primary_byte, pend_r[15:12]};
            pos_nxt = 2'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    is_free = (ent == 16'd0);
    if (cfg.fat16_mode) begin
      is_bad = (ent == F16_BAD);
      is_rsv = 1'b0;
      is_eoc = (ent >= F16_EOC);
    end else begin
      is_bad = (ent[11:0] == F12_BAD);
      is_rsv = (ent[11:0] >= F12_RSV_LO) && (ent[11:0] <= F12_RSV_HI);
      is_eoc = (ent[11:0] >= F12_EOC);
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    st_nxt   = st_r;
    fill_nxt = fill_r;
    ram_we   = 1'b0;
    if (clear) begin
      idx_nxt  = 17'd0;
      st_nxt   = '0;
      fill_nxt = '0;
    end else if (in_vld_r) begin
      if (cfg.compare_copies && (in_r.primary_byte != in_r.copy_byte) &&
          (st_r.mismatch_cnt != MISMATCH_MAX)) begin
        st_nxt.mismatch_cnt = st_r.mismatch_cnt + 24'd1;
      end
      if (ent_vld) begin
        if (idx_r == 17'd0) begin
          st_nxt.entry_zero = ent;
        end else if (idx_r == 17'd1) begin
          st_nxt.entry_one = ent;
        end else if (idx_r <= {1'b0, cfg.cluster_limit}) begin
          if (is_free) begin
            st_nxt.free_cnt = sat_inc(st_r.free_cnt);
          end else if (is_bad) begin
            st_nxt.bad_cnt = sat_inc(st_r.bad_cnt);
            if (fill_r < FW'(BAD_LIST_DEPTH)) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end else if (is_rsv) begin
            st_nxt.rsv_cnt = sat_inc(st_r.rsv_cnt);
          end else if (is_eoc) begin
            st_nxt.eoc_cnt   = sat_inc(st_r.eoc_cnt);
            st_nxt.alloc_cnt = sat_inc(st_r.alloc_cnt);
          end else begin
            st_nxt.alloc_cnt = sat_inc(st_r.alloc_cnt);
          end
        end
        if (idx_r != ENTRY_SAT) begin
          idx_nxt = idx_r + 17'd1;
        end
      end
    end
  end

  // a trailing partial group is left in pos/pend and wiped by the clear
  assign ram_waddr    = fill_r[AW-1:0];
  assign ram_wdata    = idx_r[15:0];
  assign last_pending = in_vld_r & in_r.last_byte;
  assign stats        = st_r;
  assign fill         = fill_r;
endmodule
`default_nettype wire

// ===== rtl/core/fts_emit.sv =====
`default_nettype none
module fts_emit import fts_pkg::*; #(
  parameter int BAD_LIST_DEPTH = 32,
  localparam int FW = $clog2(BAD_LIST_DEPTH + 1),
  localparam int AW = (BAD_LIST_DEPTH > 1) ? $clog2(BAD_LIST_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [FW-1:0] fill,
  input  wire fts_stats_t    stats,
  input  wire logic [7:0]    media_byte,
  input  wire logic [15:0]   ram_rdata,
  output logic [AW-1:0]      ram_raddr,
  output logic               clear,
  output logic               busy,
  output logic               out_valid,
  output fts_out_t           out_data,
  input  wire logic          out_ready
);
  emit_state_t    state_r, state_nxt;
  logic [FW-1:0]  k_r, k_nxt;
  logic           out_vld_r, out_vld_nxt;
  fts_out_t       out_r, out_nxt;
  logic           out_free;
  logic           load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= EMIT_IDLE;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_free = ~out_vld_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    load      = 1'b0;
    clear     = 1'b0;
    out_nxt   = '0;
    case (state_r)
      EMIT_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          state_nxt = EMIT_RD;
        end
      end
      EMIT_RD: begin
        // read data is registered: the data for the address set here is loaded in EMIT_LOAD
        if (k_r < fill) begin
          state_nxt = EMIT_LOAD;
        end else begin
          state_nxt = EMIT_SUM;
        end
      end
      EMIT_LOAD: begin
        out_nxt.item_kind          = ITEM_LIST;
        out_nxt.bad_cluster_number = ram_rdata;
        if (out_free) begin
          load      = 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = EMIT_RD;
        end
      end
      EMIT_SUM: begin
        out_nxt.item_kind        = ITEM_SUMMARY;
        out_nxt.free_total       = stats.free_cnt;
        out_nxt.bad_total        = stats.bad_cnt;
        out_nxt.reserved_total   = stats.rsv_cnt;
        out_nxt.end_marker_total = stats.eoc_cnt;
        out_nxt.allocated_total  = stats.alloc_cnt;
        out_nxt.mismatch_total   = stats.mismatch_cnt;
        out_nxt.entry_zero       = stats.entry_zero;
        out_nxt.entry_one        = stats.entry_one;
        out_nxt.media_differs    = (stats.entry_zero[7:0] != media_byte);
        out_nxt.final_item       = 1'b1;
        if (out_free) begin
          load      = 1'b1;
          clear     = 1'b1;
          state_nxt = EMIT_IDLE;
        end
      end
      default: begin
        state_nxt = EMIT_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign ram_raddr = k_r[AW-1:0];
  assign busy      = (state_r != EMIT_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ===== rtl/core/fat_table_statistics_unit.sv =====
// channel   dir  handshake       payload
// in_bus    in   valid / ready   primary_byte, copy_byte, last_byte
// out_bus   out  valid / ready   fts_out_t result item (list or summary)
// cfg_bus   in   valid / ready   wr_index, wr_data (ready always high)
//
// one table byte per cycle while in_bus.ready is high; each byte is
// decoded and counted in the cycle after it is taken, from the input
// register into the running totals; the input is held after a last byte
// until the listed bad clusters (registered ram read) and the summary are
// loaded; the result register frees input while a summary waits on out_bus
// synchronous active-low reset clears control and totals, not the bad list
`default_nettype none
module fat_table_statistics_unit import fts_pkg::*; #(
  parameter int BAD_LIST_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fts_in_if.sink    in_bus,
  fts_out_if.source out_bus,
  fts_cfg_if.sink   cfg_bus
);
  localparam int FW = $clog2(BAD_LIST_DEPTH + 1);
  localparam int AW = (BAD_LIST_DEPTH > 1) ? $clog2(BAD_LIST_DEPTH) : 1;

  fts_cfg_t       cfg_r, cfg_nxt;
  logic           take;
  logic           last_pending;
  logic           busy;
  logic           clear;
  fts_stats_t     stats;
  logic [FW-1:0]  fill;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [15:0]    ram_wdata;
  logic [15:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fat16_mode     <= 1'b0;
      cfg_r.cluster_limit  <= CLUSTER_LIMIT_RST;
      cfg_r.compare_copies <= 1'b0;
      cfg_r.media_byte     <= MEDIA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.data.wr_index)
        CFG_FAT16_MODE:    cfg_nxt.fat16_mode     = cfg_bus.data.wr_data[0];
        CFG_CLUSTER_LIMIT: cfg_nxt.cluster_limit  = cfg_bus.data.wr_data;
        CFG_COMPARE:       cfg_nxt.compare_copies = cfg_bus.data.wr_data[0];
        CFG_MEDIA:         cfg_nxt.media_byte     = cfg_bus.data.wr_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = ~(last_pending | busy);
  assign take          = in_bus.valid & in_bus.ready;

  fts_scan #(.BAD_LIST_DEPTH(BAD_LIST_DEPTH)) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .take         (take),
    .in_data      (in_bus.data),
    .clear        (clear),
    .last_pending (last_pending),
    .stats        (stats),
    .fill         (fill),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  fts_ram #(.WIDTH(16), .DEPTH(BAD_LIST_DEPTH)) u_bad_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fts_emit #(.BAD_LIST_DEPTH(BAD_LIST_DEPTH)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (last_pending),
    .fill       (fill),
    .stats      (stats),
    .media_byte (cfg_r.media_byte),
    .ram_rdata  (ram_rdata),
    .ram_raddr  (ram_raddr),
    .clear      (clear),
    .busy       (busy),
    .out_valid  (out_bus.valid),
    .out_data   (out_bus.data),
    .out_ready  (out_bus.ready)
  );
endmodule
`default_nettype wire

// ===== rtl/core/fts_checker.sv =====
`default_nettype none
module fts_checker import fts_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     in_last,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire fts_out_t out_data
);

  // a last-byte transaction is followed by a held input side
  a_last_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after a last-byte transaction");

  a_list_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == ITEM_LIST) |-> !in_ready)
    else $error("input ready while a list item is shown");

  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == ITEM_SUMMARY) |->
      out_data.final_item && (out_data.bad_cluster_number == 16'd0))
    else $error("summary item malformed");

  a_list_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == ITEM_LIST) |->
      !out_data.final_item && (out_data.free_total == 16'd0) &&
      (out_data.mismatch_total == 24'd0) && (out_data.entry_zero == 16'd0))
    else $error("list item carries summary fields");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fat_table_statistics_unit fts_checker u_fts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.data.last_byte),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.data)
);
`default_nettype wire
